>>> rtl/core/fmrp_pkg.sv
// ----------------------------------------------------------------------------
// fmrp_pkg
// Shared types and constants of the factor model rating predictor.
// ----------------------------------------------------------------------------
package fmrp_pkg;

  typedef enum logic [2:0] {
    KIND_PREDICT = 3'd0,
    KIND_WR_UF   = 3'd1,
    KIND_WR_IF   = 3'd2,
    KIND_WR_UB   = 3'd3,
    KIND_WR_IB   = 3'd4
  } kind_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CLAMP_EN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_EN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RMIN     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RMAX     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GBIAS    = 3'd4;

  typedef struct packed {
    logic               vld;
    logic [2:0]         kind;
    logic               uok;
    logic               iok;
    logic [3:0]         fidx;
    logic signed [15:0] wv;
  } ctrl_t;

endpackage

>>> rtl/core/fmrp_ram.sv
// ----------------------------------------------------------------------------
// fmrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmrp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/fmrp_cell.sv
// ----------------------------------------------------------------------------
// fmrp_cell
// One latent factor lane: holds factor K of every user and item, adds its
// product to the partial sum and hands the item to the next cell.
// ----------------------------------------------------------------------------
module fmrp_cell #(
  parameter int unsigned K         = 0,
  parameter int unsigned NumUsers  = 1024,
  parameter int unsigned NumItems  = 1024,
  parameter int unsigned AccW      = 40,
  localparam int unsigned UW = (NumUsers > 1) ? $clog2(NumUsers) : 1,
  localparam int unsigned IW = (NumItems > 1) ? $clog2(NumItems) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  fmrp_pkg::ctrl_t        ctrl_i,
  input  logic [UW-1:0]          uidx_i,
  input  logic [IW-1:0]          iidx_i,
  input  logic signed [AccW-1:0] acc_i,
  output fmrp_pkg::ctrl_t        ctrl_o,
  output logic [UW-1:0]          uidx_o,
  output logic [IW-1:0]          iidx_o,
  output logic signed [AccW-1:0] acc_o
);

  logic                   vld_q;
  fmrp_pkg::ctrl_t        ctrl_q;
  logic [UW-1:0]          uidx_q;
  logic [IW-1:0]          iidx_q;
  logic signed [AccW-1:0] acc_q;
  logic                   here;
  logic                   uf_we;
  logic                   if_we;
  logic [15:0]            uf_rd;
  logic [15:0]            if_rd;
  logic signed [31:0]     prod;

  assign here  = ctrl_i.vld && (32'(ctrl_i.fidx) == K);
  assign uf_we = adv_i && here && ctrl_i.uok &&
                 (ctrl_i.kind == fmrp_pkg::KIND_WR_UF);
  assign if_we = adv_i && here && ctrl_i.iok &&
                 (ctrl_i.kind == fmrp_pkg::KIND_WR_IF);

  fmrp_ram #(.Width(16), .Depth(NumUsers)) u_uf_ram (
    .clk_i,
    .we_i    (uf_we),
    .waddr_i (uidx_i),
    .wdata_i (ctrl_i.wv),
    .re_i    (adv_i),
    .raddr_i (uidx_i),
    .rdata_o (uf_rd)
  );

  fmrp_ram #(.Width(16), .Depth(NumItems)) u_if_ram (
    .clk_i,
    .we_i    (if_we),
    .waddr_i (iidx_i),
    .wdata_i (ctrl_i.wv),
    .re_i    (adv_i),
    .raddr_i (iidx_i),
    .rdata_o (if_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctrl_q <= ctrl_i;
      uidx_q <= uidx_i;
      iidx_q <= iidx_i;
      acc_q  <= acc_i;
    end
  end

  assign prod = $signed(uf_rd) * $signed(if_rd);

  always_comb begin
    ctrl_o     = ctrl_q;
    ctrl_o.vld = vld_q;
  end

  assign uidx_o = uidx_q;
  assign iidx_o = iidx_q;
  assign acc_o  = acc_q + AccW'(prod);

endmodule

>>> rtl/core/fmrp_tail.sv
// ----------------------------------------------------------------------------
// fmrp_tail
// End of the chain: bias tables, bias add, truncation to Q15.16, clamp and
// saturation into the output register.
// ----------------------------------------------------------------------------
module fmrp_tail #(
  parameter int unsigned NumUsers = 1024,
  parameter int unsigned NumItems = 1024,
  parameter int unsigned AccW     = 40,
  localparam int unsigned UW = (NumUsers > 1) ? $clog2(NumUsers) : 1,
  localparam int unsigned IW = (NumItems > 1) ? $clog2(NumItems) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  fmrp_pkg::ctrl_t        ctrl_i,
  input  logic [UW-1:0]          uidx_i,
  input  logic [IW-1:0]          iidx_i,
  input  logic signed [AccW-1:0] acc_i,
  input  logic                   clamp_en_i,
  input  logic                   bias_en_i,
  input  logic signed [7:0]      rmin_i,
  input  logic signed [7:0]      rmax_i,
  input  logic signed [15:0]     gbias_i,
  output logic                   out_vld_o,
  output logic signed [31:0]     out_pred_o,
  output logic                   out_err_o
);

  localparam logic signed [AccW-1:0] SatHi = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);

  logic                   a_vld_q;
  fmrp_pkg::ctrl_t        a_ctrl_q;
  logic signed [AccW-1:0] a_acc_q;
  logic                   ub_we;
  logic                   ib_we;
  logic [15:0]            ub_rd;
  logic [15:0]            ib_rd;
  logic signed [17:0]     bsum;
  logic signed [AccW-1:0] sum;
  logic signed [AccW-1:0] fl;

  logic                   b_vld_q;
  logic                   b_err_q;
  logic signed [AccW-1:0] b_val_q;
  logic signed [AccW-1:0] hi;
  logic signed [AccW-1:0] lo;
  logic signed [AccW-1:0] p;

  logic                   out_vld_q;
  logic signed [31:0]     out_pred_q;
  logic                   out_err_q;

  assign ub_we = adv_i && ctrl_i.vld && ctrl_i.uok &&
                 (ctrl_i.kind == fmrp_pkg::KIND_WR_UB);
  assign ib_we = adv_i && ctrl_i.vld && ctrl_i.iok &&
                 (ctrl_i.kind == fmrp_pkg::KIND_WR_IB);

  fmrp_ram #(.Width(16), .Depth(NumUsers)) u_ub_ram (
    .clk_i,
    .we_i    (ub_we),
    .waddr_i (uidx_i),
    .wdata_i (ctrl_i.wv),
    .re_i    (adv_i),
    .raddr_i (uidx_i),
    .rdata_o (ub_rd)
  );

  fmrp_ram #(.Width(16), .Depth(NumItems)) u_ib_ram (
    .clk_i,
    .we_i    (ib_we),
    .waddr_i (iidx_i),
    .wdata_i (ctrl_i.wv),
    .re_i    (adv_i),
    .raddr_i (iidx_i),
    .rdata_o (ib_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q   <= ctrl_i.vld && (ctrl_i.kind == fmrp_pkg::KIND_PREDICT);
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q;
    end
  end

  // bias add and floor drop of 8 fraction bits
  assign bsum = 18'(gbias_i) + 18'($signed(ub_rd)) + 18'($signed(ib_rd));
  assign sum  = a_acc_q + (bias_en_i ? (AccW'(bsum) <<< 16) : '0);
  assign fl   = sum >>> 8;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_ctrl_q <= ctrl_i;
      a_acc_q  <= acc_i;
      b_err_q  <= !(a_ctrl_q.uok && a_ctrl_q.iok);
      b_val_q  <= fl;
    end
  end

  assign hi = AccW'(rmax_i) <<< 16;
  assign lo = AccW'(rmin_i) <<< 16;

  always_comb begin
    p = b_val_q;
    if (clamp_en_i) begin
      if (p > hi) p = hi;
      if (p < lo) p = lo;
    end
    if (p > SatHi) p = SatHi;
    if (p < SatLo) p = SatLo;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_err_q  <= b_err_q;
      out_pred_q <= b_err_q ? 32'sd0 : p[31:0];
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_pred_o = out_pred_q;
  assign out_err_o  = out_err_q;

endmodule

>>> rtl/core/factor_model_rating_predictor.sv
// ----------------------------------------------------------------------------
// factor_model_rating_predictor
// Biased matrix factorization predictor built as a chain of factor cells.
// ----------------------------------------------------------------------------
// A predict item passes each factor cell, then tail registers a, b and out.
// Throughput: one item per cycle; the whole chain advances together and holds
// while a result is stalled at the output register.
// Reset clears valid bits and sets the config registers to their reset
// values; the tables are undefined until written, with no clearing pass.
module factor_model_rating_predictor #(
  parameter int unsigned NUM_USERS = 1024,
  parameter int unsigned NUM_ITEMS = 1024,
  parameter int unsigned FACTORS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fmrp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fmrp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       in_kind_i,
  input  logic [10:0]                      in_user_id_i,
  input  logic [10:0]                      in_item_id_i,
  input  logic [3:0]                       in_factor_index_i,
  input  logic signed [15:0]               in_write_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               out_prediction_o,
  output logic                             out_id_error_o
);

  localparam int unsigned UW   = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int unsigned IW   = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int unsigned AccW = 36 + $clog2(FACTORS + 1);

  logic               clamp_en_q;
  logic               bias_en_q;
  logic signed [7:0]  rmin_q;
  logic signed [7:0]  rmax_q;
  logic signed [15:0] gbias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_en_q <= 1'b1;
      bias_en_q  <= 1'b1;
      rmin_q     <= 8'sd1;
      rmax_q     <= 8'sd5;
      gbias_q    <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fmrp_pkg::CFG_CLAMP_EN: clamp_en_q <= cfg_data_i[0];
        fmrp_pkg::CFG_BIAS_EN:  bias_en_q  <= cfg_data_i[0];
        fmrp_pkg::CFG_RMIN:     rmin_q     <= cfg_data_i[7:0];
        fmrp_pkg::CFG_RMAX:     rmax_q     <= cfg_data_i[7:0];
        fmrp_pkg::CFG_GBIAS:    gbias_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic        adv;
  logic [16:0] uid_m1;
  logic [16:0] iid_m1;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign uid_m1     = 17'(in_user_id_i) - 17'd1;
  assign iid_m1     = 17'(in_item_id_i) - 17'd1;

  fmrp_pkg::ctrl_t        ctrl   [FACTORS+1];
  logic [UW-1:0]          uidx   [FACTORS+1];
  logic [IW-1:0]          iidx   [FACTORS+1];
  logic signed [AccW-1:0] acc    [FACTORS+1];

  always_comb begin
    ctrl[0].vld  = in_valid_i;
    ctrl[0].kind = in_kind_i;
    ctrl[0].uok  = (in_user_id_i != 11'd0) && (32'(in_user_id_i) <= NUM_USERS);
    ctrl[0].iok  = (in_item_id_i != 11'd0) && (32'(in_item_id_i) <= NUM_ITEMS);
    ctrl[0].fidx = in_factor_index_i;
    ctrl[0].wv   = in_write_value_i;
  end

  assign uidx[0] = uid_m1[UW-1:0];
  assign iidx[0] = iid_m1[IW-1:0];
  assign acc[0]  = '0;

  for (genvar k = 0; k < FACTORS; k++) begin : g_cell
    fmrp_cell #(
      .K        (k),
      .NumUsers (NUM_USERS),
      .NumItems (NUM_ITEMS),
      .AccW     (AccW)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .adv_i  (adv),
      .ctrl_i (ctrl[k]),
      .uidx_i (uidx[k]),
      .iidx_i (iidx[k]),
      .acc_i  (acc[k]),
      .ctrl_o (ctrl[k+1]),
      .uidx_o (uidx[k+1]),
      .iidx_o (iidx[k+1]),
      .acc_o  (acc[k+1])
    );
  end

  fmrp_tail #(
    .NumUsers (NUM_USERS),
    .NumItems (NUM_ITEMS),
    .AccW     (AccW)
  ) u_tail (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .ctrl_i     (ctrl[FACTORS]),
    .uidx_i     (uidx[FACTORS]),
    .iidx_i     (iidx[FACTORS]),
    .acc_i      (acc[FACTORS]),
    .clamp_en_i (clamp_en_q),
    .bias_en_i  (bias_en_q),
    .rmin_i     (rmin_q),
    .rmax_i     (rmax_q),
    .gbias_i    (gbias_q),
    .out_vld_o  (out_valid_o),
    .out_pred_o (out_prediction_o),
    .out_err_o  (out_id_error_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_id_error_o |-> out_prediction_o == 32'sd0)
    else $error("id error result with nonzero prediction");

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_id_error_o && clamp_en_q && (rmin_q <= rmax_q) &&
    $stable(clamp_en_q) && $stable(rmin_q) && $stable(rmax_q) |->
    (out_prediction_o <= (32'(rmax_q) <<< 16)) &&
    (out_prediction_o >= (32'(rmin_q) <<< 16)))
    else $error("clamped prediction outside rating bounds");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");
`endif

endmodule

>>> bench/fmrp_checker.sv
// ----------------------------------------------------------------------------
// fmrp_checker
// Watches the item and result channels of the rating predictor, keeps its
// own copy of the tables and registers, predicts each rating and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fmrp_checker #(
  parameter int unsigned NUM_USERS = 1024,
  parameter int unsigned NUM_ITEMS = 1024,
  parameter int unsigned FACTORS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fmrp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fmrp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [2:0]                    in_kind_i,
  input  logic [10:0]                   in_user_id_i,
  input  logic [10:0]                   in_item_id_i,
  input  logic [3:0]                    in_factor_index_i,
  input  logic signed [15:0]            in_write_value_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic signed [31:0]            out_prediction_o,
  input  logic                          out_id_error_o,
  output int                            fail_cnt,
  output int                            pending
);

  typedef struct packed {
    logic signed [31:0] rating;
    logic               id_err;
  } rating_t;

  rating_t            rating_q[$];
  logic signed [15:0] user_fac [NUM_USERS][FACTORS];
  logic signed [15:0] item_fac [NUM_ITEMS][FACTORS];
  logic signed [15:0] user_b   [NUM_USERS];
  logic signed [15:0] item_b   [NUM_ITEMS];
  logic               clamp_en, bias_en;
  logic signed [7:0]  rmin, rmax;
  logic signed [15:0] gbias;

  function automatic logic signed [31:0] rating_of(int u, int i);
    logic signed [63:0] acc, hi, lo;
    acc = 0;
    for (int k = 0; k < FACTORS; k++) acc += user_fac[u][k] * item_fac[i][k];
    if (bias_en) acc += (gbias + user_b[u] + item_b[i]) * 65536;
    acc = acc >>> 8;
    if (clamp_en) begin
      hi = rmax * 65536;
      lo = rmin * 65536;
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_en <= 1'b1;
      bias_en  <= 1'b1;
      rmin     <= 8'sd1;
      rmax     <= 8'sd5;
      gbias    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fmrp_pkg::CFG_CLAMP_EN: clamp_en <= cfg_data_i[0];
        fmrp_pkg::CFG_BIAS_EN:  bias_en  <= cfg_data_i[0];
        fmrp_pkg::CFG_RMIN:     rmin     <= cfg_data_i[7:0];
        fmrp_pkg::CFG_RMAX:     rmax     <= cfg_data_i[7:0];
        fmrp_pkg::CFG_GBIAS:    gbias    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  initial fail_cnt = 0;

  always @(posedge clk_i) begin
    bit      uok, iok;
    int      u, i;
    rating_t got, exp_r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      uok = in_user_id_i >= 1 && in_user_id_i <= NUM_USERS;
      iok = in_item_id_i >= 1 && in_item_id_i <= NUM_ITEMS;
      u = uok ? in_user_id_i - 1 : 0;
      i = iok ? in_item_id_i - 1 : 0;
      case (in_kind_i)
        fmrp_pkg::KIND_WR_UF:
          if (uok) user_fac[u][in_factor_index_i] = in_write_value_i;
        fmrp_pkg::KIND_WR_IF:
          if (iok) item_fac[i][in_factor_index_i] = in_write_value_i;
        fmrp_pkg::KIND_WR_UB: if (uok) user_b[u] = in_write_value_i;
        fmrp_pkg::KIND_WR_IB: if (iok) item_b[i] = in_write_value_i;
        fmrp_pkg::KIND_PREDICT: begin
          if (uok && iok) rating_q.push_back('{rating_of(u, i), 1'b0});
          else rating_q.push_back('{32'sd0, 1'b1});
        end
        default: ;
      endcase
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_prediction_o, out_id_error_o};
      if (rating_q.size() == 0) begin
        $error("unexpected result: prediction %0d id_error %0b", got.rating, got.id_err);
        fail_cnt++;
      end else begin
        exp_r = rating_q.pop_front();
        if (got.rating !== exp_r.rating) begin
          $error("prediction: expected %0d, got %0d", exp_r.rating, got.rating);
          fail_cnt++;
        end
        if (got.id_err !== exp_r.id_err) begin
          $error("id_error: expected %0b, got %0b", exp_r.id_err, got.id_err);
          fail_cnt++;
        end
      end
    end
    pending = rating_q.size();
  end

endmodule

>>> bench/tb_factor_model_rating_predictor.sv
// ----------------------------------------------------------------------------
// tb_factor_model_rating_predictor
// Loads factor and bias rows for a pool of ids, runs directed and random
// predict and write items under several register settings and idling
// patterns, and checks every rating through the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_factor_model_rating_predictor;

  localparam int unsigned Factors = 16;
  localparam int Drain = Factors + 8;
  localparam int WdogLimit = 5000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [fmrp_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [fmrp_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [2:0]                    in_kind = '0;
  logic [10:0]                   in_uid = '0;
  logic [10:0]                   in_iid = '0;
  logic [3:0]                    in_fidx = '0;
  logic signed [15:0]            in_wval = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [31:0]            out_pred;
  logic                          out_err;
  int                            fail_cnt, pending;
  int                            tx_idle_pct = 0, rx_stall_pct = 0;
  int                            hold_cnt = 0;
  bit                            hold_req = 0;
  int                            wdog = 0;

  int pool_ids[8] = '{1, 2, 3, 341, 512, 682, 1023, 1024};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  factor_model_rating_predictor u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_kind_i(in_kind), .in_user_id_i(in_uid), .in_item_id_i(in_iid),
    .in_factor_index_i(in_fidx), .in_write_value_i(in_wval),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_prediction_o(out_pred), .out_id_error_o(out_err)
  );

  fmrp_checker u_chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_kind_i(in_kind), .in_user_id_i(in_uid), .in_item_id_i(in_iid),
    .in_factor_index_i(in_fidx), .in_write_value_i(in_wval),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_prediction_o(out_pred), .out_id_error_o(out_err),
    .fail_cnt, .pending
  );

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic [2:0] kind, int uid, int iid, int fidx, int wval);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_uid   <= uid[10:0];
    in_iid   <= iid[10:0];
    in_fidx  <= fidx[3:0];
    in_wval  <= wval[15:0];
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [fmrp_pkg::CfgIdxW-1:0] idx, int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[15:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_row(int id, int lo, int hi);
    for (int k = 0; k < Factors; k++) begin
      send(fmrp_pkg::KIND_WR_UF, id, 0, k, $urandom_range(hi, lo) - 32768);
      send(fmrp_pkg::KIND_WR_IF, 0, id, k, $urandom_range(hi, lo) - 32768);
    end
    send(fmrp_pkg::KIND_WR_UB, id, 0, $urandom_range(15), $urandom_range(65535) - 32768);
    send(fmrp_pkg::KIND_WR_IB, 0, id, $urandom_range(15), $urandom_range(65535) - 32768);
  endtask

  function automatic int pick_id();
    return pool_ids[$urandom_range(7)];
  endfunction

  function automatic int bad_id();
    return $urandom_range(1) ? 0 : $urandom_range(2047, 1025);
  endfunction

  task automatic random_items(int n);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 55) send(fmrp_pkg::KIND_PREDICT, pick_id(), pick_id(), $urandom_range(15),
                       $urandom_range(65535));
      else if (r < 65) begin
        if ($urandom_range(1))
          send(fmrp_pkg::KIND_PREDICT, bad_id(), $urandom_range(2047), 0, 0);
        else send(fmrp_pkg::KIND_PREDICT, $urandom_range(2047), bad_id(), 0, 0);
      end else if (r < 90) begin
        case ($urandom_range(3))
          0: send(fmrp_pkg::KIND_WR_UF, pick_id(), $urandom_range(2047),
                  $urandom_range(15), $urandom_range(65535));
          1: send(fmrp_pkg::KIND_WR_IF, $urandom_range(2047), pick_id(),
                  $urandom_range(15), $urandom_range(65535));
          2: send(fmrp_pkg::KIND_WR_UB, pick_id(), $urandom_range(2047),
                  $urandom_range(15), $urandom_range(65535));
          default: send(fmrp_pkg::KIND_WR_IB, $urandom_range(2047), pick_id(),
                        $urandom_range(15), $urandom_range(65535));
        endcase
      end else begin
        // noise: unknown kinds and writes to random or bad ids
        send($urandom_range(1) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 1)),
             $urandom_range(2047), $urandom_range(2047), $urandom_range(15),
             $urandom_range(65535));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pool_ids[p]) load_row(pool_ids[p], 0, 65535);

    // directed: extreme factors on the top ids, bad ids, ignored items
    for (int k = 0; k < Factors; k++) begin
      send(fmrp_pkg::KIND_WR_UF, 1024, 0, k, 32767);
      send(fmrp_pkg::KIND_WR_IF, 0, 1024, k, (k % 2) ? -32768 : 32767);
    end
    send(fmrp_pkg::KIND_PREDICT, 1024, 1024, 0, 0);
    send(fmrp_pkg::KIND_WR_UB, 1, 0, 0, -32768);
    send(fmrp_pkg::KIND_WR_IB, 0, 1, 0, 32767);
    send(fmrp_pkg::KIND_PREDICT, 1, 1, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 0, 1, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 1, 0, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 1025, 5, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 2047, 2047, 0, 0);
    send(fmrp_pkg::KIND_WR_UF, 0, 0, 15, 32767);
    send(fmrp_pkg::KIND_WR_IF, 0, 2047, 15, 32767);
    send(fmrp_pkg::KIND_WR_UB, 2047, 0, 0, 1);
    send(fmrp_pkg::KIND_WR_IB, 0, 0, 0, 1);
    send(3'd5, 1, 1, 0, 0);
    send(3'd6, 2, 2, 0, 0);
    send(3'd7, 3, 3, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 1024, 1, 0, 0);
    send(fmrp_pkg::KIND_PREDICT, 3, 1024, 0, 0);
    random_items(60);
    drain();

    cfg_write(fmrp_pkg::CFG_CLAMP_EN, 0);
    cfg_write(fmrp_pkg::CFG_BIAS_EN, 0);
    tx_idle_pct = 81;
    random_items(70);
    drain();

    cfg_write(fmrp_pkg::CFG_CLAMP_EN, 1);
    cfg_write(fmrp_pkg::CFG_BIAS_EN, 1);
    cfg_write(fmrp_pkg::CFG_RMIN, -128);
    cfg_write(fmrp_pkg::CFG_RMAX, 127);
    cfg_write(fmrp_pkg::CFG_GBIAS, -32768);
    tx_idle_pct = 0;
    rx_stall_pct = 81;
    random_items(70);
    drain();

    // inverted bounds
    cfg_write(fmrp_pkg::CFG_RMIN, 5);
    cfg_write(fmrp_pkg::CFG_RMAX, 1);
    cfg_write(fmrp_pkg::CFG_GBIAS, 32767);
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    random_items(70);
    drain();

    cfg_write(fmrp_pkg::CFG_CLAMP_EN, 0);
    cfg_write(fmrp_pkg::CFG_GBIAS, $urandom_range(65535));
    cfg_write(3'd7, $urandom_range(65535));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    random_items(70);
    drain();

    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
